// ===== rtl/aes_pkg.sv =====
// aes_pkg: shared types, op codes and GF(2^8) helpers for the AES-128 engine.
// No dependencies.
package aes_pkg;

    localparam int KeyWords  = 44;
    localparam int NumRounds = 10;
    localparam int KeyIdxW   = 6;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_ENCRYPT = 2'd1,
        OP_DECRYPT = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]         op;
        logic [KeyIdxW-1:0] key_word_index;
        logic [31:0]        key_word;
        logic [63:0]        block_high;
        logic [63:0]        block_low;
    } t_in_word;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out_word;

    // control from sequencer to round unit
    typedef struct packed {
        logic inverse;
        logic first;   // initial key addition only
        logic last;    // skip (inv)mix columns
    } t_round_ctl;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] p;
        logic [7:0] t;
        p = 8'h00;
        t = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) p = p ^ t;
            t = xtime(t);
        end
        gf_mul = p;
    endfunction

    function automatic logic [7:0] gf_mul8(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] t;
        p = 8'h00;
        t = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ t;
            t = xtime(t);
        end
        gf_mul8 = p;
    endfunction

    function automatic logic [7:0] gf_inv(input logic [7:0] a);
        logic [7:0] r;
        logic [7:0] base;
        r = 8'h01;
        base = a;
        for (int i = 0; i < 8; i++) begin
            if (i != 0) r = gf_mul8(r, base);
            base = gf_mul8(base, base);
        end
        gf_inv = r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
        rotl8 = (x << n) | (x >> (8 - n));
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] b;
        b = gf_inv(x);
        sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] inv_sbox_calc(input logic [7:0] y);
        inv_sbox_calc = gf_inv(rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6) ^ 8'h05);
    endfunction

    // constant tables, folded at elaboration
    typedef logic [7:0] t_sbox [256];

    function automatic t_sbox make_sbox(input logic inverse);
        t_sbox t;
        for (int i = 0; i < 256; i++) begin
            t[i] = inverse ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
        end
        make_sbox = t;
    endfunction

    localparam t_sbox SBOX     = make_sbox(1'b0);
    localparam t_sbox INV_SBOX = make_sbox(1'b1);

endpackage

// ===== rtl/aes_round.sv =====
// aes_round: one AES round (forward or inverse) on a 128-bit state.
// Depends on aes_pkg. State bytes in FIPS-197 order, byte 0 in bits 127:120.
module aes_round (
    input  logic [127:0]          i_state,
    input  logic [127:0]          i_key,
    input  aes_pkg::t_round_ctl   i_ctl,
    output logic [127:0]          o_state
);

    logic [7:0] s  [16];
    logic [7:0] sr [16];
    logic [7:0] sb [16];
    logic [7:0] mx [16];
    logic [7:0] ak [16];
    logic [7:0] k  [16];
    logic [127:0] res;

    always_comb begin
        for (int n = 0; n < 16; n++) begin
            s[n] = i_state[127 - 8*n -: 8];
            k[n] = i_key[127 - 8*n -: 8];
        end
        // shift rows: byte n = row n%4, col n/4
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (i_ctl.inverse)
                    sr[4*c + r] = s[4*((c + 4 - r) % 4) + r];
                else
                    sr[4*c + r] = s[4*((c + r) % 4) + r];
            end
        end
        for (int n = 0; n < 16; n++) begin
            sb[n] = i_ctl.inverse ? aes_pkg::INV_SBOX[sr[n]] : aes_pkg::SBOX[sr[n]];
        end
        // forward: sub, shift, mix, key; inverse: shift, sub, key, invmix
        for (int n = 0; n < 16; n++) begin
            ak[n] = i_ctl.inverse ? (sb[n] ^ k[n]) : sb[n];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (i_ctl.inverse)
                    mx[4*c + r] = aes_pkg::gf_mul(ak[4*c + r], 4'he)
                                ^ aes_pkg::gf_mul(ak[4*c + (r+1)%4], 4'hb)
                                ^ aes_pkg::gf_mul(ak[4*c + (r+2)%4], 4'hd)
                                ^ aes_pkg::gf_mul(ak[4*c + (r+3)%4], 4'h9);
                else
                    mx[4*c + r] = aes_pkg::xtime(ak[4*c + r])
                                ^ aes_pkg::xtime(ak[4*c + (r+1)%4]) ^ ak[4*c + (r+1)%4]
                                ^ ak[4*c + (r+2)%4] ^ ak[4*c + (r+3)%4];
            end
        end
        for (int n = 0; n < 16; n++) begin
            if (i_ctl.first)
                res[127 - 8*n -: 8] = s[n] ^ k[n];
            else if (i_ctl.inverse)
                res[127 - 8*n -: 8] = i_ctl.last ? ak[n] : mx[n];
            else
                res[127 - 8*n -: 8] = (i_ctl.last ? ak[n] : mx[n]) ^ k[n];
        end
        o_state = res;
    end

endmodule

// ===== rtl/aes128_block_cipher.sv =====
// aes128_block_cipher: AES-128 ECB engine, iterative, one round per cycle.
// Depends on aes_pkg and aes_round.
// Each block runs the initial key add plus ten rounds before its result is valid.
// A new block is accepted only in idle, so not before the last result has been taken;
// the result is held until taken. Key loads are accepted in idle.
// Reset (sync, active low) clears control only; key table undefined until written.
module aes128_block_cipher (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  aes_pkg::t_in_word    i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output aes_pkg::t_out_word   o_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } t_state;

    t_state r_state;
    logic [3:0]   r_round;     // 0..10 round step count
    logic         r_inv;
    logic [127:0] r_blk;
    // one row per round key; lane 3 holds word 4r+0 (column 0, top bits)
    logic [3:0][31:0] r_key_tab [aes_pkg::NumRounds + 1];
    logic [127:0] w_key;
    logic [127:0] w_next;
    logic [3:0]   w_kround;
    aes_pkg::t_round_ctl w_ctl;
    logic         w_acc;

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign o_data.result_high = r_blk[127:64];
    assign o_data.result_low  = r_blk[63:0];
    assign w_acc = i_valid && o_ready;

    // round key index: encrypt walks up, decrypt walks down
    assign w_kround = r_inv ? 4'(aes_pkg::NumRounds) - r_round : r_round;
    assign w_key = r_key_tab[w_kround];

    assign w_ctl.inverse = r_inv;
    assign w_ctl.first   = (r_round == 4'd0);
    assign w_ctl.last    = (r_round == 4'(aes_pkg::NumRounds));

    aes_round u_round (
        .i_state (r_blk),
        .i_key   (w_key),
        .i_ctl   (w_ctl),
        .o_state (w_next)
    );

    // key table: written on load words with an in-range index
    always_ff @(posedge i_clk) begin
        if (w_acc && i_data.op == aes_pkg::OP_LOAD
            && i_data.key_word_index < 6'(aes_pkg::KeyWords)) begin
            r_key_tab[i_data.key_word_index[5:2]][2'd3 - i_data.key_word_index[1:0]]
                <= i_data.key_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_round <= '0;
            r_inv   <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_acc && (i_data.op == aes_pkg::OP_ENCRYPT
                                  || i_data.op == aes_pkg::OP_DECRYPT)) begin
                        r_state <= ST_RUN;
                        r_round <= '0;
                        r_inv   <= (i_data.op == aes_pkg::OP_DECRYPT);
                        r_blk   <= {i_data.block_high, i_data.block_low};
                    end
                end
                ST_RUN: begin
                    r_blk <= w_next;
                    if (r_round == 4'(aes_pkg::NumRounds)) r_state <= ST_OUT;
                    else r_round <= r_round + 4'd1;
                end
                ST_OUT: begin
                    if (i_ready) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round <= 4'(aes_pkg::NumRounds)) else $error("round count out of range");
    a_out_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_round) == 4'(aes_pkg::NumRounds))
        else $error("result without ten rounds");
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while holding result");

endmodule
